// ===== hw/rtl/lzwd_pkg.sv =====
package lzwd_pkg;

  localparam int CODE_W         = 12;
  localparam int DICT_AW        = CODE_W;
  localparam int DICT_SIZE      = 1 << DICT_AW;
  localparam int NFC_W          = DICT_AW + 1;
  localparam int LITERALS       = 256;
  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 13;
  localparam int LEN_SAT        = (1 << LEN_W) - 1;
  localparam int MAX_STRING_LEN = 64;
  localparam int STACK_AW       = $clog2(MAX_STRING_LEN);
  localparam int CNT_W          = STACK_AW + 1;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] suffix;
    logic [BYTE_W-1:0] first;
    logic [LEN_W-1:0]  len;
  } dict_entry_t;

  localparam int DICT_ENTRY_W = $bits(dict_entry_t);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNDEF    = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_ADD,
    S_WALK,
    S_WALK_DATA,
    S_EMIT_RD,
    S_EMIT_LD,
    S_ERROR
  } state_e;

endpackage

// ===== hw/rtl/lzwd_ram.sv =====
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lzw_decoder_core.sv =====
// lzw_decoder_core: twelve-bit lzw decompressor
//
// input channel: one code per request on code_word_i (in_valid_i / in_stall_o).
// output channel: one decoded byte per request on out_byte_o, with last_of_run_o
// on the final byte of a code and status_o (0 ok, 1 undefined code, 2 string
// too long). an error code gives a single request with byte zero.
// the dictionary lives in one 4096 x 41 ram (prefix, suffix, first byte,
// length); decoded bytes are reversed through a 64 x 8 stack ram.
// a code is taken only while the block is idle. a known code above 255 other than the
// next free code first has its length looked up; the chain walk then reads each
// dictionary entry and uses the registered read data, writes the closing literal to the
// stack, and each byte leaves the stack by a read and then a load into the output
// register. the next code is taken in the cycle after the last byte is loaded.
// the result sits in an output register, so the next code is accepted while
// the last byte still waits; a stalled receiver holds the block in the emit
// phase with the byte and flags frozen.
// reset (rst_ni low, asynchronous) empties the dictionary logically (next free
// code 256) and makes the block wait for a literal first code; no ram clearing
// pass is needed.
module lzw_decoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lzwd_pkg::CODE_W-1:0] code_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lzwd_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        last_of_run_o,
  output logic [1:0]                  status_o
);
  import lzwd_pkg::*;

  state_e              state_q, state_d;
  logic [NFC_W-1:0]    nfc_q, nfc_d;
  logic                awaiting_q, awaiting_d;
  logic [CODE_W-1:0]   prev_q, prev_d;
  logic [BYTE_W-1:0]   prev_first_q, prev_first_d;
  logic [LEN_W-1:0]    prev_len_q, prev_len_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic [BYTE_W-1:0]   cur_first_q, cur_first_d;
  logic [LEN_W-1:0]    cur_len_q, cur_len_d;
  status_e             err_q, err_d;
  logic [CODE_W-1:0]   walk_c_q, walk_c_d;
  logic [CNT_W-1:0]    walk_idx_q, walk_idx_d;
  logic [CNT_W-1:0]    emit_idx_q, emit_idx_d;
  logic                out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]   out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;
  status_e             out_status_q, out_status_d;

  logic                dict_we, dict_re;
  logic [DICT_AW-1:0]  dict_waddr, dict_raddr;
  dict_entry_t         dict_wdata, dict_rdata;
  logic                stack_we, stack_re;
  logic [STACK_AW-1:0] stack_waddr, stack_raddr;
  logic [BYTE_W-1:0]   stack_wdata, stack_rdata;

  logic                in_req, full, is_lit_in, is_next_in, undef_in, needs_lookup;
  logic [NFC_W-1:0]    code_ext;
  logic [LEN_W-1:0]    prev_len_inc;
  logic                out_free, walk_lit, walk_last, emit_last, too_long;
  logic [CNT_W-1:0]    walk_slot, emit_next;

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_req       = in_valid_i && !in_stall_o;
  assign full         = (nfc_q >= NFC_W'(DICT_SIZE));
  assign code_ext     = {1'b0, code_word_i};
  assign is_lit_in    = (code_word_i < CODE_W'(LITERALS));
  assign is_next_in   = !awaiting_q && (code_ext == nfc_q);
  assign undef_in     = awaiting_q ? !is_lit_in
                                   : ((code_ext > nfc_q) || ((code_ext == nfc_q) && full));
  assign needs_lookup = !awaiting_q && !is_lit_in && !is_next_in;
  assign prev_len_inc = (prev_len_q == LEN_W'(LEN_SAT)) ? prev_len_q
                                                         : prev_len_q + LEN_W'(1);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign walk_lit     = (walk_c_q < CODE_W'(LITERALS));
  assign walk_last    = (walk_idx_q == CNT_W'(1));
  assign walk_slot    = walk_idx_q - CNT_W'(1);
  assign emit_next    = emit_idx_q + CNT_W'(1);
  assign emit_last    = (emit_next == cur_len_q[CNT_W-1:0]);
  assign too_long     = (cur_len_q > LEN_W'(MAX_STRING_LEN));

  lzwd_ram #(
    .WIDTH(DICT_ENTRY_W),
    .DEPTH(DICT_SIZE)
  ) u_dict_ram (
    .clk_i  (clk_i),
    .we_i   (dict_we),
    .waddr_i(dict_waddr),
    .wdata_i(dict_wdata),
    .re_i   (dict_re),
    .raddr_i(dict_raddr),
    .rdata_o(dict_rdata)
  );

  lzwd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_STRING_LEN)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stack_we),
    .waddr_i(stack_waddr),
    .wdata_i(stack_wdata),
    .re_i   (stack_re),
    .raddr_i(stack_raddr),
    .rdata_o(stack_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_req) begin
          if (undef_in) begin
            state_d = S_ERROR;
          end else if (needs_lookup) begin
            state_d = S_LOOKUP;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_LOOKUP:    state_d = S_ADD;
      S_ADD:       state_d = too_long ? S_ERROR : S_WALK;
      S_WALK: begin
        if (!walk_lit) begin
          state_d = S_WALK_DATA;
        end else if (walk_last) begin
          state_d = S_EMIT_RD;
        end
      end
      S_WALK_DATA: state_d = walk_last ? S_EMIT_RD : S_WALK;
      S_EMIT_RD:   state_d = S_EMIT_LD;
      S_EMIT_LD: begin
        if (out_free) begin
          state_d = emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_ERROR: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    nfc_d        = nfc_q;
    awaiting_d   = awaiting_q;
    prev_d       = prev_q;
    prev_first_d = prev_first_q;
    prev_len_d   = prev_len_q;
    code_d       = code_q;
    cur_first_d  = cur_first_q;
    cur_len_d    = cur_len_q;
    err_d        = err_q;
    walk_c_d     = walk_c_q;
    walk_idx_d   = walk_idx_q;
    emit_idx_d   = emit_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    dict_we      = 1'b0;
    dict_waddr   = nfc_q[DICT_AW-1:0];
    dict_wdata   = '{prefix: prev_q,
                     suffix: (({1'b0, code_q} == nfc_q) ? prev_first_q : cur_first_q),
                     first:  prev_first_q,
                     len:    prev_len_inc};
    dict_re      = 1'b0;
    dict_raddr   = walk_c_q;
    stack_we     = 1'b0;
    stack_waddr  = walk_slot[STACK_AW-1:0];
    stack_wdata  = walk_c_q[BYTE_W-1:0];
    stack_re     = 1'b0;
    stack_raddr  = emit_idx_q[STACK_AW-1:0];
    case (state_q)
      S_IDLE: begin
        dict_raddr = code_word_i;
        if (in_req) begin
          code_d  = code_word_i;
          err_d   = ST_UNDEF;
          dict_re = !undef_in && needs_lookup;
          if (is_next_in) begin
            cur_first_d = prev_first_q;
            cur_len_d   = prev_len_inc;
          end else begin
            cur_first_d = code_word_i[BYTE_W-1:0];
            cur_len_d   = LEN_W'(1);
          end
        end
      end
      S_LOOKUP: begin
        cur_first_d = dict_rdata.first;
        cur_len_d   = dict_rdata.len;
      end
      S_ADD: begin
        if (!awaiting_q && !full) begin
          dict_we = 1'b1;
          nfc_d   = nfc_q + NFC_W'(1);
        end
        awaiting_d   = 1'b0;
        prev_d       = code_q;
        prev_first_d = cur_first_q;
        prev_len_d   = cur_len_q;
        err_d        = ST_TOO_LONG;
        walk_c_d     = code_q;
        walk_idx_d   = cur_len_q[CNT_W-1:0];
        emit_idx_d   = '0;
      end
      S_WALK: begin
        if (walk_lit) begin
          stack_we   = 1'b1;
          walk_c_d   = '0;
          walk_idx_d = walk_slot;
        end else begin
          dict_re = 1'b1;
        end
      end
      S_WALK_DATA: begin
        stack_we    = 1'b1;
        stack_wdata = dict_rdata.suffix;
        walk_c_d    = dict_rdata.prefix;
        walk_idx_d  = walk_slot;
      end
      S_EMIT_RD: begin
        stack_re = 1'b1;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = stack_rdata;
          out_last_d   = emit_last;
          out_status_d = ST_OK;
          emit_idx_d   = emit_next;
        end
      end
      S_ERROR: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = '0;
          out_last_d   = 1'b1;
          out_status_d = err_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nfc_q       <= NFC_W'(LITERALS);
      awaiting_q  <= 1'b1;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nfc_q       <= nfc_d;
      awaiting_q  <= awaiting_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_first_q <= prev_first_d;
    prev_len_q   <= prev_len_d;
    code_q       <= code_d;
    cur_first_q  <= cur_first_d;
    cur_len_q    <= cur_len_d;
    err_q        <= err_d;
    walk_c_q     <= walk_c_d;
    walk_idx_q   <= walk_idx_d;
    emit_idx_q   <= emit_idx_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;
  assign status_o      = out_status_q;

  a_nfc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfc_q >= NFC_W'(LITERALS)) && (nfc_q <= NFC_W'(DICT_SIZE)))
    else $error("next free code out of range");

  a_awaiting_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> (nfc_q == NFC_W'(LITERALS)))
    else $error("dictionary grew before first code");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> in_stall_o)
    else $error("request taken while previous code still in work");

  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WALK) || (state_q == S_WALK_DATA)) |->
      ((walk_idx_q != '0) && (walk_idx_q <= CNT_W'(MAX_STRING_LEN))))
    else $error("stack index out of range during walk");

  a_nfc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfc_q != $past(nfc_q)) |-> ($past(state_q) == S_ADD))
    else $error("dictionary grew outside the add step");

endmodule

// ===== tb/sv/tb_lzw_decoder_core.sv =====
`timescale 1ns / 100ps

module tb_lzw_decoder_core;
  import lzwd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_CODES   = 60;
  localparam int REPORT_MAX     = 10;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
    status_e           status;
  } decoded_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CODE_W-1:0] code_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;
  logic [1:0]        status;

  // decoder shadow state
  logic [CODE_W-1:0] dict_prefix [DICT_SIZE];
  logic [BYTE_W-1:0] dict_suffix [DICT_SIZE];
  logic [BYTE_W-1:0] dict_first  [DICT_SIZE];
  logic [LEN_W-1:0]  dict_len    [DICT_SIZE];
  logic [CODE_W-1:0] prev_code = '0;
  logic [NFC_W-1:0]  next_free = NFC_W'(LITERALS);
  bit                awaiting_first = 1'b1;

  decoded_t          decoded_q[$];
  logic [CODE_W-1:0] code_q[$];

  // stream generator view of the dictionary
  int gen_next_free = LITERALS;
  bit gen_started = 1'b0;

  int  send_wait = 0;
  int  recv_wait = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  int  codes_done = 0;
  int  bytes_done = 0;
  int  undef_seen = 0;
  int  too_long_seen = 0;
  int  fail_count = 0;
  int  idle_cycles = 0;
  int  long_code;
  int  pick;
  int  i;

  lzw_decoder_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .code_word_i  (code_word),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .last_of_run_o(last_of_run),
    .status_o     (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void queue_byte(logic [BYTE_W-1:0] value, logic last, status_e st);
    decoded_t d;
    d.value  = value;
    d.last   = last;
    d.status = st;
    decoded_q.push_back(d);
  endfunction

  function automatic logic [BYTE_W-1:0] first_of(logic [CODE_W-1:0] c);
    return (c < LITERALS) ? c[BYTE_W-1:0] : dict_first[c];
  endfunction

  function automatic logic [LEN_W-1:0] len_of(logic [CODE_W-1:0] c);
    return (c < LITERALS) ? LEN_W'(1) : dict_len[c];
  endfunction

  function automatic void emit_string(logic [CODE_W-1:0] c);
    logic [BYTE_W-1:0] chars [MAX_STRING_LEN];
    logic [CODE_W-1:0] walk;
    int                n;
    int                k;
    n = int'(len_of(c));
    if (n > MAX_STRING_LEN || n == 0) begin
      queue_byte('0, 1'b1, ST_TOO_LONG);
      return;
    end
    walk = c;
    for (k = n - 1; k >= 0; k--) begin
      if (walk < LITERALS) begin
        chars[k] = walk[BYTE_W-1:0];
        walk = '0;
      end else begin
        chars[k] = dict_suffix[walk];
        walk = dict_prefix[walk];
      end
    end
    for (k = 0; k < n; k++) queue_byte(chars[k], k == n - 1, ST_OK);
  endfunction

  function automatic void decode_code(logic [CODE_W-1:0] code);
    bit                full;
    logic [BYTE_W-1:0] add_byte;
    logic [LEN_W:0]    n;
    full = next_free >= DICT_SIZE;
    if (awaiting_first) begin
      if (code >= LITERALS) begin
        queue_byte('0, 1'b1, ST_UNDEF);
        return;
      end
      awaiting_first = 1'b0;
      prev_code = code;
      emit_string(code);
      return;
    end
    if ({1'b0, code} > next_free || ({1'b0, code} == next_free && full)) begin
      queue_byte('0, 1'b1, ST_UNDEF);
      return;
    end
    add_byte = ({1'b0, code} == next_free) ? first_of(prev_code) : first_of(code);
    if (!full) begin
      n = {1'b0, len_of(prev_code)} + 1'b1;
      if (n > LEN_SAT) n = (LEN_W + 1)'(LEN_SAT);
      dict_prefix[next_free[CODE_W-1:0]] = prev_code;
      dict_suffix[next_free[CODE_W-1:0]] = add_byte;
      dict_first[next_free[CODE_W-1:0]]  = first_of(prev_code);
      dict_len[next_free[CODE_W-1:0]]    = n[LEN_W-1:0];
      next_free = next_free + 1'b1;
    end
    prev_code = code;
    emit_string(code);
  endfunction

  function automatic void queue_code(int c);
    if (!gen_started) begin
      if (c < LITERALS) gen_started = 1'b1;
    end else if (c < gen_next_free || (c == gen_next_free && gen_next_free < DICT_SIZE)) begin
      if (gen_next_free < DICT_SIZE) gen_next_free++;
    end
    code_q.push_back(c[CODE_W-1:0]);
  endfunction

  // request side
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      code_word <= '0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_code(code_word);
        codes_done++;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 6);
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (code_q.size() > 0) begin
          in_valid  <= 1'b1;
          code_word <= code_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk or negedge rst_n) begin
    decoded_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        bytes_done++;
        if (status == ST_UNDEF) undef_seen++;
        if (status == ST_TOO_LONG) too_long_seen++;
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result: byte %0d last %0d status %0d",
                     out_byte, last_of_run, status);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.value || last_of_run !== want.last ||
              status !== want.status) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("mismatch: exp byte %0d last %0d status %0d, got %0d %0d %0d",
                       want.value, want.last, want.status, out_byte, last_of_run, status);
          end
        end
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
      end
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", idle_cycles);
        $display("lzw_decoder_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    // directed: non-literal first codes, literal extremes, known code,
    // code equal to next free entry, undefined codes
    queue_code(4095);
    queue_code(256);
    queue_code(0);
    queue_code(255);
    queue_code(256);
    queue_code(258);
    queue_code(4095);
    queue_code(260);
    queue_code(259);
    queue_code(128);
    queue_code(1);
    queue_code(170);
    queue_code(85);
    queue_code(2048);
    queue_code(262);

    // random well-formed streams with some undefined codes mixed in
    for (i = 0; i < RANDOM_CODES; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 || gen_next_free == LITERALS) queue_code($urandom_range(0, LITERALS - 1));
      else if (pick < 65) queue_code($urandom_range(LITERALS, gen_next_free - 1));
      else if (pick < 82) queue_code(gen_next_free);
      else if (gen_next_free < DICT_SIZE - 1)
        queue_code($urandom_range(gen_next_free + 1, DICT_SIZE - 1));
      else queue_code($urandom_range(0, DICT_SIZE - 1));
    end

    // grow one string past the length limit, then reuse it
    queue_code($urandom_range(0, LITERALS - 1));
    for (i = 0; i < MAX_STRING_LEN + 2; i++) queue_code(gen_next_free);
    long_code = gen_next_free - 1;
    queue_code(long_code);
    queue_code($urandom_range(0, LITERALS - 1));

    // top code, the long string again, first dictionary entry, random codes
    queue_code(DICT_SIZE - 1);
    queue_code(long_code);
    queue_code(LITERALS);
    for (i = 0; i < 20; i++) queue_code($urandom_range(0, DICT_SIZE - 1));

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (code_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("decoded %0d codes into %0d results, %0d undefined and %0d too long",
             codes_done, bytes_done, undef_seen, too_long_seen);
    $display("dictionary grew to next free code %0d, %0d mismatches", next_free,
             fail_count);
    if (fail_count == 0) begin
      $display("lzw_decoder_core verification clean");
    end else begin
      $display("lzw_decoder_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_ram.sv
hw/rtl/lzw_decoder_core.sv
tb/sv/tb_lzw_decoder_core.sv
